### rtl/core/tzr_pkg.sv
// Shared types, opcodes and fixed-point helpers of the textured z-buffer rasteriser.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tzr_pkg;

    // Operation codes of the command channel
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_TEXEL  = 3'd1;
    localparam logic [2:0] OP_VERTEX = 3'd2;
    localparam logic [2:0] OP_DRAW   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] VTX_SLOTS = 2'd3;

    // Divider operand widths: divisor holds an edge length up to 4096
    localparam int DEN_W = 13;
    localparam int REM_W = DEN_W + 1;
    localparam int QCNT_W = 5;

    localparam logic [31:0] RECIP_NUM = 32'd65535;
    localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [1:0]         vertex_slot;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic [15:0]        vertex_depth;
        logic [7:0]         tex_u;
        logic [7:0]         tex_v;
        logic [15:0]        texel_index;
        logic [31:0]        texel_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic [31:0] pixel_depth;
    } t_out_item;

    typedef struct packed {
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic [15:0]        z;
        logic [7:0]         u;
        logic [7:0]         v;
    } t_vtx;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] z;
        logic [31:0] u;
        logic [31:0] v;
        logic [31:0] dx;
        logic [31:0] dz;
        logic [31:0] du;
        logic [31:0] dv;
    } t_edge;

    typedef struct packed {
        logic             start;
        logic             sgn;
        logic [31:0]      num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DONE,
        S_EI_D1,
        S_EI_W1,
        S_EI_D2,
        S_EI_W2,
        S_EI_MUL,
        S_EI_FIN,
        S_SEG0,
        S_SEG1,
        S_ROW,
        S_ROW_STEP,
        S_SP_D1,
        S_SP_W1,
        S_SP_D2,
        S_SP_W2,
        S_SP_MUL,
        S_SP_FIN,
        S_PIX_RD,
        S_PIX_WR
    } t_state;

    function automatic logic [31:0] asr1(input logic [31:0] a);
        return {a[31], a[31:1]};
    endfunction

    function automatic logic [31:0] asr16(input logic [31:0] a);
        return {{16{a[31]}}, a[31:16]};
    endfunction

    function automatic logic [31:0] sx32(input logic [11:0] a);
        return {{20{a[11]}}, a};
    endfunction

endpackage

`default_nettype wire

### rtl/core/tzr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, signed dividend option.
// Depends on tzr_pkg for the request and response structs.
`timescale 1ns / 1ps
`default_nettype none

module tzr_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tzr_pkg::t_div_req i_req,
    output tzr_pkg::t_div_rsp      o_rsp
);

    logic                       r_busy;
    logic                       r_done;
    logic [tzr_pkg::QCNT_W-1:0] r_cnt;
    logic [tzr_pkg::REM_W-1:0]  r_rem;
    logic [31:0]                r_quo;
    logic [tzr_pkg::DEN_W-1:0]  r_den;
    logic                       r_neg;

    logic [tzr_pkg::REM_W-1:0]  shifted;
    logic                       fits;

    // Trial subtract of the shifted partial remainder
    always_comb begin
        shifted = {r_rem[tzr_pkg::REM_W-2:0], r_quo[31]};
        fits    = (shifted >= {1'b0, r_den});
    end

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load magnitude, then shift one quotient bit in each cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.sgn & i_req.num[31];
            r_quo <= (i_req.sgn & i_req.num[31]) ? (32'd0 - i_req.num) : i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= fits ? (shifted - {1'b0, r_den}) : shifted;
            r_quo <= {r_quo[30:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? (32'd0 - r_quo) : r_quo;

endmodule

`default_nettype wire

### rtl/core/textured_zbuffer_triangle_raster.sv
// Top level of the textured z-buffer triangle rasteriser: sequencer, stores, edge walker.
// Depends on tzr_pkg and tzr_div.
//
//  channel | direction | handshake                   | payload
//  in      | to block  | i_in_valid / o_in_ready     | i_in_item  (tzr_pkg::t_in_item)
//  out     | from block| o_out_valid / i_out_ready   | o_out_item (tzr_pkg::t_out_item)
//
// One command is taken at a time; one result is returned per command.
// A depth clear sweeps every pixel of the depth store. A draw consists of edge set-ups, dropped
// rows, visible spans (a set-up plus the row step) and pixels; the shared bit-serial divider
// sets the set-up cost.
// After reset the depth and frame stores are swept to zero while the input is not ready.
// A finished result waits in the final state until the output register is free to take it.
`timescale 1ns / 1ps
`default_nettype none

module textured_zbuffer_triangle_raster #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire tzr_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output tzr_pkg::t_out_item      o_out_item
);

    localparam int NPIX = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW   = $clog2(NPIX);
    localparam int XW   = $clog2(SCREEN_WIDTH);
    localparam int NW   = XW + 1;
    localparam logic [AW-1:0]      LAST_PIX = AW'(NPIX - 1);
    localparam logic signed [12:0] XLIM     = 13'(SCREEN_WIDTH);
    localparam logic signed [12:0] YLIM     = 13'(SCREEN_HEIGHT);
    localparam logic signed [23:0] XMAX     = 24'(SCREEN_WIDTH - 1);
    localparam logic signed [23:0] XMAX2    = 24'(SCREEN_WIDTH - 2);

    tzr_pkg::t_state r_state, n_state;

    // Control state
    logic              r_clr_frm;
    logic [AW-1:0]     r_clr;
    logic              r_out_valid;
    tzr_pkg::t_out_item r_out;
    tzr_pkg::t_vtx     r_vtx [0:2];

    // Draw working state
    tzr_pkg::t_vtx     r_p [0:2];
    tzr_pkg::t_edge    r_e [0:1];
    logic              r_esel;
    logic [1:0]        r_va, r_vb;
    logic              r_seg;
    logic [1:0]        r_k;
    logic signed [11:0] r_y, r_yend;
    logic [31:0]       r_pre, r_prod;
    logic [31:0]       r_edx, r_edz, r_edu;
    logic [31:0]       r_zl, r_zr, r_ul, r_ur, r_vl, r_vr;
    logic [31:0]       r_sdz, r_sdu, r_sdv;
    logic [31:0]       r_z, r_u, r_v;
    logic [NW-1:0]     r_n, r_i;
    logic [AW-1:0]     r_pix;
    logic              r_rd_in;
    tzr_pkg::t_out_item r_res;

    // Stores
    logic [31:0] r_dep_mem [0:NPIX-1];
    logic [31:0] r_frm_mem [0:NPIX-1];
    logic [31:0] r_tex_mem [0:65535];
    logic [31:0] r_dep_rd, r_frm_rd, r_tex_rd;

    logic              dep_we, frm_we;
    logic [AW-1:0]     dep_wa, dep_ra;
    logic [31:0]       dep_wd, frm_wd;
    logic [15:0]       tex_ra;
    logic [31:0]       mul_a;
    tzr_pkg::t_div_req div_req;
    tzr_pkg::t_div_rsp div_rsp;

    logic              in_xfer;
    logic              out_free;
    logic              rd_in;
    logic [AW-1:0]     rd_addr;
    tzr_pkg::t_vtx     srt [0:2];
    tzr_pkg::t_vtx     tv;
    tzr_pkg::t_vtx     va, vb;
    logic [tzr_pkg::DEN_W-1:0] e_len;
    logic signed [23:0] xa, xb, xl0, xr0, xl_c, xr_c;
    logic              b_left, sp_drop;
    logic [31:0]       zz;
    logic              pass;
    logic              pix_last;

    tzr_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Bounds and address of a pixel read
    always_comb begin
        rd_in = ($signed(i_in_item.pos_x) >= 0) && ($signed(i_in_item.pos_x) < XLIM)
             && ($signed(i_in_item.pos_y) >= 0) && ($signed(i_in_item.pos_y) < YLIM);
        rd_addr = AW'(AW'(i_in_item.pos_y[11:0]) * AW'(SCREEN_WIDTH))
                + AW'(i_in_item.pos_x[11:0]);
    end

    // Sort a copy of the vertices by y
    always_comb begin
        srt[0] = r_vtx[0];
        srt[1] = r_vtx[1];
        srt[2] = r_vtx[2];
        if (srt[1].y > srt[2].y) begin
            tv = srt[1]; srt[1] = srt[2]; srt[2] = tv;
        end else begin
            tv = srt[0];
        end
        if (srt[0].y > srt[2].y) begin
            tv = srt[0]; srt[0] = srt[2]; srt[2] = tv;
        end
        if (srt[0].y > srt[1].y) begin
            tv = srt[0]; srt[0] = srt[1]; srt[1] = tv;
        end
    end

    // Edge end points and length
    always_comb begin
        va    = r_p[r_va];
        vb    = r_p[r_vb];
        e_len = {vb.y[11], vb.y} - {va.y[11], va.y} + 13'd1;
    end

    // Span ends, clipping and drop decision for the current row
    always_comb begin
        xa     = $signed(r_e[0].x[31:8]);
        xb     = $signed(r_e[1].x[31:8]);
        b_left = (xb < xa);
        xl0    = b_left ? xb : xa;
        xr0    = b_left ? xa : xb;
        xl_c   = (xl0 < 0) ? 24'sd0 : xl0;
        xr_c   = (xr0 > XMAX) ? XMAX : xr0;
        sp_drop = (xa == xb) || r_y[11] || ($signed(r_y) >= YLIM)
               || (xr0 < 24'sd1) || (xl0 > XMAX2) || (xl_c == xr_c);
    end

    // Pixel depth test
    always_comb begin
        zz       = {8'd0, r_z[31:8]};
        pass     = (r_dep_rd < zz);
        pix_last = (r_i == r_n - 1'b1);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tzr_pkg::S_CLEAR: begin
                if (r_clr == LAST_PIX) begin
                    n_state = r_clr_frm ? tzr_pkg::S_IDLE : tzr_pkg::S_DONE;
                end
            end
            tzr_pkg::S_IDLE: begin
                if (in_xfer) begin
                    case (i_in_item.opcode)
                        tzr_pkg::OP_CLEAR: n_state = tzr_pkg::S_CLEAR;
                        tzr_pkg::OP_DRAW: begin
                            n_state = (srt[0].y == srt[2].y) ? tzr_pkg::S_DONE
                                                             : tzr_pkg::S_EI_D1;
                        end
                        tzr_pkg::OP_READ: n_state = tzr_pkg::S_READ;
                        default: n_state = tzr_pkg::S_DONE;
                    endcase
                end
            end
            tzr_pkg::S_READ: n_state = tzr_pkg::S_DONE;
            tzr_pkg::S_DONE: if (out_free) n_state = tzr_pkg::S_IDLE;
            tzr_pkg::S_EI_D1: n_state = tzr_pkg::S_EI_W1;
            tzr_pkg::S_EI_W1: if (div_rsp.done) n_state = tzr_pkg::S_EI_D2;
            tzr_pkg::S_EI_D2: n_state = tzr_pkg::S_EI_W2;
            tzr_pkg::S_EI_W2: if (div_rsp.done) n_state = tzr_pkg::S_EI_MUL;
            tzr_pkg::S_EI_MUL: if (r_k == 2'd2) n_state = tzr_pkg::S_EI_FIN;
            tzr_pkg::S_EI_FIN: n_state = r_esel ? tzr_pkg::S_ROW : tzr_pkg::S_SEG0;
            tzr_pkg::S_SEG0: begin
                n_state = (r_p[1].y > r_p[0].y) ? tzr_pkg::S_EI_D1 : tzr_pkg::S_SEG1;
            end
            tzr_pkg::S_SEG1: begin
                n_state = (r_p[2].y > r_p[1].y) ? tzr_pkg::S_EI_D1 : tzr_pkg::S_DONE;
            end
            tzr_pkg::S_ROW: n_state = sp_drop ? tzr_pkg::S_ROW_STEP : tzr_pkg::S_SP_D1;
            tzr_pkg::S_ROW_STEP: begin
                if (r_y + 12'sd1 == r_yend) begin
                    n_state = r_seg ? tzr_pkg::S_DONE : tzr_pkg::S_SEG1;
                end else begin
                    n_state = tzr_pkg::S_ROW;
                end
            end
            tzr_pkg::S_SP_D1: n_state = tzr_pkg::S_SP_W1;
            tzr_pkg::S_SP_W1: if (div_rsp.done) n_state = tzr_pkg::S_SP_D2;
            tzr_pkg::S_SP_D2: n_state = tzr_pkg::S_SP_W2;
            tzr_pkg::S_SP_W2: if (div_rsp.done) n_state = tzr_pkg::S_SP_MUL;
            tzr_pkg::S_SP_MUL: if (r_k == 2'd1) n_state = tzr_pkg::S_SP_FIN;
            tzr_pkg::S_SP_FIN: n_state = tzr_pkg::S_PIX_RD;
            tzr_pkg::S_PIX_RD: n_state = tzr_pkg::S_PIX_WR;
            tzr_pkg::S_PIX_WR: n_state = pix_last ? tzr_pkg::S_ROW_STEP : tzr_pkg::S_PIX_RD;
            default: n_state = tzr_pkg::S_IDLE;
        endcase
    end

    // Store controls, divider request and multiplier operand
    always_comb begin
        o_in_ready = (r_state == tzr_pkg::S_IDLE);
        dep_we  = 1'b0;
        frm_we  = 1'b0;
        dep_wa  = r_pix;
        dep_wd  = zz;
        frm_wd  = r_tex_rd | tzr_pkg::ALPHA_OPAQUE;
        dep_ra  = (r_state == tzr_pkg::S_IDLE) ? rd_addr : r_pix;
        tex_ra  = {r_v[15:8], r_u[15:8]};
        div_req = '0;
        mul_a   = '0;
        case (r_state)
            tzr_pkg::S_CLEAR: begin
                dep_we = 1'b1;
                frm_we = r_clr_frm;
                dep_wa = r_clr;
                dep_wd = '0;
                frm_wd = '0;
            end
            tzr_pkg::S_PIX_WR: begin
                dep_we = pass;
                frm_we = pass;
            end
            tzr_pkg::S_EI_D1: begin
                div_req.start = 1'b1;
                div_req.num   = tzr_pkg::RECIP_NUM;
                div_req.den   = e_len;
            end
            tzr_pkg::S_EI_D2: begin
                div_req.start = 1'b1;
                div_req.sgn   = 1'b1;
                div_req.num   = (32'(vb.z) - 32'(va.z)) << 8;
                div_req.den   = e_len;
            end
            tzr_pkg::S_SP_D1: begin
                div_req.start = 1'b1;
                div_req.num   = tzr_pkg::RECIP_NUM;
                div_req.den   = tzr_pkg::DEN_W'(r_n) + 1'b1;
            end
            tzr_pkg::S_SP_D2: begin
                div_req.start = 1'b1;
                div_req.sgn   = 1'b1;
                div_req.num   = r_zr - r_zl;
                div_req.den   = tzr_pkg::DEN_W'(r_n);
            end
            tzr_pkg::S_EI_MUL: begin
                case (r_k)
                    2'd0: mul_a = (tzr_pkg::sx32(vb.x) - tzr_pkg::sx32(va.x)) << 8;
                    2'd1: mul_a = (32'(vb.u) - 32'(va.u)) << 8;
                    default: mul_a = (32'(vb.v) - 32'(va.v)) << 8;
                endcase
            end
            tzr_pkg::S_SP_MUL: begin
                mul_a = (r_k == 2'd0) ? (r_ur - r_ul) : (r_vr - r_vl);
            end
            default: begin
                dep_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tzr_pkg::S_CLEAR;
            r_clr       <= '0;
            r_clr_frm   <= 1'b1;
            r_out_valid <= 1'b0;
            r_vtx[0]    <= '0;
            r_vtx[1]    <= '0;
            r_vtx[2]    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == tzr_pkg::S_CLEAR) begin
                r_clr <= (r_clr == LAST_PIX) ? '0 : r_clr + 1'b1;
            end
            if (in_xfer && i_in_item.opcode == tzr_pkg::OP_CLEAR) begin
                r_clr_frm <= 1'b0;
            end
            // Hold the vertex written by a set command
            if (in_xfer && i_in_item.opcode == tzr_pkg::OP_VERTEX
                    && i_in_item.vertex_slot != tzr_pkg::VTX_SLOTS) begin
                r_vtx[i_in_item.vertex_slot] <= '{
                    x: i_in_item.pos_x, y: i_in_item.pos_y, z: i_in_item.vertex_depth,
                    u: i_in_item.tex_u, v: i_in_item.tex_v};
            end
            // Output register: load on completion, drop on transfer
            if (r_state == tzr_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result and draw datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * r_pre;
        case (r_state)
            tzr_pkg::S_IDLE: begin
                r_res   <= '0;
                r_rd_in <= rd_in;
                r_p[0]  <= srt[0];
                r_p[1]  <= srt[1];
                r_p[2]  <= srt[2];
                r_esel  <= 1'b0;
                r_va    <= 2'd0;
                r_vb    <= 2'd2;
            end
            tzr_pkg::S_READ: begin
                if (r_rd_in) begin
                    r_res.pixel_color <= r_frm_rd;
                    r_res.pixel_depth <= r_dep_rd;
                end
            end
            tzr_pkg::S_DONE: begin
                if (out_free) r_out <= r_res;
            end
            tzr_pkg::S_EI_W1, tzr_pkg::S_SP_W1: begin
                r_pre <= div_rsp.quo;
                r_k   <= 2'd0;
            end
            tzr_pkg::S_EI_W2: r_edz <= div_rsp.quo;
            tzr_pkg::S_SP_W2: r_sdz <= div_rsp.quo;
            tzr_pkg::S_EI_MUL: begin
                r_k <= r_k + 1'b1;
                if (r_k == 2'd1) r_edx <= tzr_pkg::asr16(r_prod);
                if (r_k == 2'd2) r_edu <= tzr_pkg::asr16(r_prod);
            end
            tzr_pkg::S_EI_FIN: begin
                r_e[r_esel].dx <= r_edx;
                r_e[r_esel].dz <= r_edz;
                r_e[r_esel].du <= r_edu;
                r_e[r_esel].dv <= tzr_pkg::asr16(r_prod);
                r_e[r_esel].x  <= (tzr_pkg::sx32(va.x) << 8) + tzr_pkg::asr1(r_edx);
                r_e[r_esel].z  <= (32'(va.z) << 8) + tzr_pkg::asr1(r_edz);
                r_e[r_esel].u  <= (32'(va.u) << 8) + tzr_pkg::asr1(r_edu);
                r_e[r_esel].v  <= (32'(va.v) << 8)
                                + tzr_pkg::asr1(tzr_pkg::asr16(r_prod));
            end
            tzr_pkg::S_SEG0: begin
                r_esel <= 1'b1;
                r_va   <= 2'd0;
                r_vb   <= 2'd1;
                r_seg  <= 1'b0;
                r_y    <= r_p[0].y;
                r_yend <= r_p[1].y;
            end
            tzr_pkg::S_SEG1: begin
                r_esel <= 1'b1;
                r_va   <= 2'd1;
                r_vb   <= 2'd2;
                r_seg  <= 1'b1;
                r_y    <= r_p[1].y;
                r_yend <= r_p[2].y;
            end
            tzr_pkg::S_ROW: begin
                r_zl  <= b_left ? r_e[1].z : r_e[0].z;
                r_zr  <= b_left ? r_e[0].z : r_e[1].z;
                r_ul  <= b_left ? r_e[1].u : r_e[0].u;
                r_ur  <= b_left ? r_e[0].u : r_e[1].u;
                r_vl  <= b_left ? r_e[1].v : r_e[0].v;
                r_vr  <= b_left ? r_e[0].v : r_e[1].v;
                r_n   <= NW'(xr_c - xl_c);
                r_pix <= AW'(AW'(r_y[11:0]) * AW'(SCREEN_WIDTH)) + AW'(xl_c[XW-1:0]);
            end
            tzr_pkg::S_ROW_STEP: begin
                r_y <= r_y + 12'sd1;
                for (int j = 0; j < 2; j++) begin
                    r_e[j].x <= r_e[j].x + r_e[j].dx;
                    r_e[j].z <= r_e[j].z + r_e[j].dz;
                    r_e[j].u <= r_e[j].u + r_e[j].du;
                    r_e[j].v <= r_e[j].v + r_e[j].dv;
                end
            end
            tzr_pkg::S_SP_MUL: begin
                r_k <= r_k + 1'b1;
                if (r_k == 2'd1) r_sdu <= tzr_pkg::asr16(r_prod);
            end
            tzr_pkg::S_SP_FIN: begin
                r_sdv <= tzr_pkg::asr16(r_prod);
                r_z   <= r_zl + tzr_pkg::asr1(r_sdz);
                r_u   <= r_ul + tzr_pkg::asr1(r_sdu);
                r_v   <= r_vl + tzr_pkg::asr1(tzr_pkg::asr16(r_prod));
                r_i   <= '0;
            end
            tzr_pkg::S_PIX_WR: begin
                r_z   <= r_z + r_sdz;
                r_u   <= r_u + r_sdu;
                r_v   <= r_v + r_sdv;
                r_i   <= r_i + 1'b1;
                r_pix <= r_pix + 1'b1;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    // Depth store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (dep_we) r_dep_mem[dep_wa] <= dep_wd;
        r_dep_rd <= r_dep_mem[dep_ra];
    end

    // Frame store: shares the write address with the depth store
    always_ff @(posedge i_clk) begin
        if (frm_we) r_frm_mem[dep_wa] <= frm_wd;
        r_frm_rd <= r_frm_mem[dep_ra];
    end

    // Texture store: written by texel load commands
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in_item.opcode == tzr_pkg::OP_TEXEL) begin
            r_tex_mem[i_in_item.texel_index] <= i_in_item.texel_value;
        end
        r_tex_rd <= r_tex_mem[tex_ra];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire
